FILE: rtl/core/mrhm_pkg.sv
// Shared types, codes and constants of the run-hour meter.
package mrhm_pkg;

   // width of the elapsed counter and the on/off totals
   localparam int COUNT_BITS = 32;

   localparam int DEBOUNCE_BITS = 10;
   localparam int TIMEOUT_BITS  = 32;
   localparam int SECONDS_BITS  = 32;
   localparam int TICKS_BITS    = 32;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 10'd50;
   localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RESET  = 32'd60000;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_TIMEOUT  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_PAUSE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_START  = 3'd1,
      EV_PAUSE  = 3'd2,
      EV_RESUME = 3'd3,
      EV_FINISH = 3'd4
   } event_type;

   typedef struct packed {
      logic [DEBOUNCE_BITS-1:0] debounce_ticks;
      logic [TIMEOUT_BITS-1:0]  timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic                     qualified_level;
      logic [DEBOUNCE_BITS-1:0] stable_count;
      mode_type                 run_mode;
      logic [COUNT_BITS-1:0]    elapsed;
      logic [COUNT_BITS-1:0]    on_total;
      logic [COUNT_BITS-1:0]    off_total;
      logic [SECONDS_BITS-1:0]  start_stamp;
      logic [SECONDS_BITS-1:0]  end_stamp;
   } meter_state_type;

endpackage

FILE: rtl/core/mrhm_step.sv
// Per-tick update: pin debounce, elapsed counter and the mode machine.
module mrhm_step (
   input  mrhm_pkg::meter_state_type                  cur_state,
   input  mrhm_pkg::cfg_type                          cfg,
   input  logic                                       motor_forward,
   input  logic                                       motor_reverse,
   input  logic [mrhm_pkg::SECONDS_BITS-1:0]          wall_seconds,
   output mrhm_pkg::meter_state_type                  nxt_state,
   output mrhm_pkg::event_type                        tick_event
);
   import mrhm_pkg::*;

   logic                  raw_level;
   logic                  timed_out;
   logic [COUNT_BITS-1:0] elapsed_inc;

   assign raw_level = motor_forward | motor_reverse;

   always_comb begin
      nxt_state  = cur_state;
      tick_event = EV_NONE;

      // debounce: accept a new level once it has differed on debounce_ticks + 1 ticks in a row
      if (raw_level == cur_state.qualified_level) begin
         nxt_state.stable_count = '0;
      end else if (cur_state.stable_count >= cfg.debounce_ticks) begin
         nxt_state.qualified_level = raw_level;
         nxt_state.stable_count    = '0;
      end else begin
         nxt_state.stable_count = cur_state.stable_count + 1'b1;
      end

      // saturating tick counter
      if (cur_state.elapsed != {COUNT_BITS{1'b1}}) begin
         elapsed_inc = cur_state.elapsed + 1'b1;
      end else begin
         elapsed_inc = cur_state.elapsed;
      end
      nxt_state.elapsed = elapsed_inc;

      timed_out = 64'(elapsed_inc) >= 64'(cfg.timeout_ticks);

      unique case (cur_state.run_mode)
         MODE_RUN: begin
            if (!nxt_state.qualified_level) begin
               nxt_state.run_mode  = MODE_PAUSE;
               nxt_state.end_stamp = wall_seconds;
               nxt_state.on_total  = cur_state.on_total + elapsed_inc;
               nxt_state.elapsed   = '0;
               tick_event          = EV_PAUSE;
            end
         end
         MODE_PAUSE: begin
            if (nxt_state.qualified_level) begin
               nxt_state.run_mode  = MODE_RUN;
               nxt_state.off_total = cur_state.off_total + elapsed_inc;
               nxt_state.elapsed   = '0;
               tick_event          = EV_RESUME;
            end else if (timed_out) begin
               nxt_state.run_mode = MODE_IDLE;
               tick_event         = EV_FINISH;
            end
         end
         default: begin
            // idle, and the unused code which behaves as idle
            nxt_state.run_mode = MODE_IDLE;
            if (nxt_state.qualified_level) begin
               nxt_state.run_mode    = MODE_RUN;
               nxt_state.start_stamp = wall_seconds;
               nxt_state.elapsed     = '0;
               nxt_state.on_total    = '0;
               nxt_state.off_total   = '0;
               tick_event            = EV_START;
            end
         end
      endcase
   end

endmodule

FILE: rtl/core/machine_run_hour_meter.sv
// Top level of the machine run-hour meter: request/result registers, state and CSRs.
// Each request is one time tick and yields exactly one result. A request can be taken
// in every cycle while the result side does not stall; its result appears on the rsp_ side
// once the request has landed in an input register at acceptance and the state update has
// then written the result register. The debounce, counter and mode update form a
// combinational loop on the state registers, which allows one tick per cycle when not stalled.
// The input register lets one further request in while a result waits to be taken.
// The on/off totals wrap and the stamps hold until next written; the elapsed counter
// saturates. CSRs are written with csr_we; index 0 is the debounce length in ticks,
// index 1 the paused-tick timeout. No clearing pass after reset.
module machine_run_hour_meter (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // motor_forward, motor_reverse, wall_seconds, zero pad
   // result
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // event_res, mode, on_ticks, off_ticks, start_seconds, end_seconds, zero pad
   output logic [135:0] rsp_tdata,
   // configuration
   input  logic                               csr_we,
   input  mrhm_pkg::csr_index_type            csr_index,
   input  logic [mrhm_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import mrhm_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   meter_state_type         state_ff, state_in;
   event_type               tick_event;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_forward_ff, s1_reverse_ff;
   logic [SECONDS_BITS-1:0] s1_seconds_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   event_type               rsp_event_ff;
   mode_type                rsp_mode_ff;
   logic [TICKS_BITS-1:0]   rsp_on_ff, rsp_off_ff;
   logic [SECONDS_BITS-1:0] rsp_start_ff, rsp_end_ff;

   logic                    out_free;
   logic                    advance;
   logic                    req_accept;
   logic [63:0]             on_ext, off_ext;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks = csr_wdata[DEBOUNCE_BITS-1:0];
            CSR_TIMEOUT:  cfg_in.timeout_ticks  = csr_wdata[TIMEOUT_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_forward_ff <= req_tdata[0];
         s1_reverse_ff <= req_tdata[1];
         s1_seconds_ff <= req_tdata[33:2];
      end
   end

   mrhm_step u_step (
      .cur_state     (state_ff),
      .cfg           (cfg_ff),
      .motor_forward (s1_forward_ff),
      .motor_reverse (s1_reverse_ff),
      .wall_seconds  (s1_seconds_ff),
      .nxt_state     (state_in),
      .tick_event    (tick_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.qualified_level <= 1'b0;
         state_ff.stable_count    <= '0;
         state_ff.run_mode        <= MODE_IDLE;
         state_ff.elapsed         <= '0;
         state_ff.on_total        <= '0;
         state_ff.off_total       <= '0;
         state_ff.start_stamp     <= '0;
         state_ff.end_stamp       <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   assign on_ext  = 64'(state_in.on_total);
   assign off_ext = 64'(state_in.off_total);

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= tick_event;
         rsp_mode_ff  <= state_in.run_mode;
         rsp_on_ff    <= on_ext[TICKS_BITS-1:0];
         rsp_off_ff   <= off_ext[TICKS_BITS-1:0];
         rsp_start_ff <= state_in.start_stamp;
         rsp_end_ff   <= state_in.end_stamp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_end_ff, rsp_start_ff, rsp_off_ff, rsp_on_ff,
                        rsp_mode_ff, rsp_event_ff};

   // a start always leaves the operation running with cleared totals
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EV_START) |->
         (rsp_mode_ff == MODE_RUN && rsp_on_ff == '0 && rsp_off_ff == '0))
      else $error("start result without running mode or with non-zero totals");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EV_FINISH) |-> rsp_mode_ff == MODE_IDLE)
      else $error("finish result without idle mode");

   // start, pause and resume clear the elapsed counter
   a_change_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      (advance && (tick_event == EV_PAUSE || tick_event == EV_RESUME
                   || tick_event == EV_START)) |=> state_ff.elapsed == '0)
      else $error("elapsed counter not cleared on mode change");

   // both registers full and the result stalled: no further request may enter
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken with both stages full");

   a_request_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost before the input register");

endmodule

FILE: verif/machine_run_hour_meter_tb.sv
// Self-checking testbench for the machine run-hour meter: random-gap stream driver and monitor.
module machine_run_hour_meter_tb;
   import mrhm_pkg::*;

   typedef struct {
      bit          fwd;
      bit          rev;
      logic [31:0] secs;
      bit          drain;   // hold this request back until every result is in
   } meter_tick_type;

   typedef struct {
      event_type   ev;
      mode_type    md;
      logic [31:0] on_ticks;
      logic [31:0] off_ticks;
      logic [31:0] start_sec;
      logic [31:0] end_sec;
   } meter_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_we = 1'b0;
   csr_index_type csr_index = CSR_DEBOUNCE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   machine_run_hour_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted meter state and register copies
   logic [DEBOUNCE_BITS-1:0] cfg_debounce = DEBOUNCE_RESET;
   logic [TIMEOUT_BITS-1:0]  cfg_timeout  = TIMEOUT_RESET;
   logic                     lvl_q = 1'b0;
   logic [DEBOUNCE_BITS-1:0] stable_cnt = '0;
   mode_type                 mode_q = MODE_IDLE;
   logic [COUNT_BITS-1:0]    elapsed_cnt = '0;
   logic [COUNT_BITS-1:0]    on_sum = '0;
   logic [COUNT_BITS-1:0]    off_sum = '0;
   logic [31:0]              start_sec = '0;
   logic [31:0]              end_sec = '0;

   meter_tick_type   pending_ticks[$];
   meter_result_type meter_expected[$];
   meter_tick_type   cur_tick;
   logic          req_fire_seen = 1'b0;
   logic          rsp_fire_seen = 1'b0;
   int            req_gap = 0, req_burst = 0;
   int            rsp_wait = 0, rsp_burst = 0;
   int            hold_left = 0;
   bit            hold_req = 1'b0, hold_ack = 1'b0;
   int            mismatches = 0;
   logic [31:0]   wall_now = 32'd1000;

   function automatic meter_result_type advance_meter(meter_tick_type t);
      meter_result_type r;
      logic raw;
      raw = t.fwd | t.rev;
      r.ev = EV_NONE;
      if (raw == lvl_q)
         stable_cnt = '0;
      else if (stable_cnt >= cfg_debounce) begin
         lvl_q = raw;
         stable_cnt = '0;
      end else
         stable_cnt = stable_cnt + 1'b1;
      if (elapsed_cnt != '1)
         elapsed_cnt = elapsed_cnt + 1'b1;
      case (mode_q)
         MODE_RUN: begin
            if (!lvl_q) begin
               mode_q = MODE_PAUSE;
               end_sec = t.secs;
               on_sum = on_sum + elapsed_cnt;
               elapsed_cnt = '0;
               r.ev = EV_PAUSE;
            end
         end
         MODE_PAUSE: begin
            if (lvl_q) begin
               mode_q = MODE_RUN;
               off_sum = off_sum + elapsed_cnt;
               elapsed_cnt = '0;
               r.ev = EV_RESUME;
            end else if (elapsed_cnt >= cfg_timeout) begin
               mode_q = MODE_IDLE;
               r.ev = EV_FINISH;
            end
         end
         default: begin
            mode_q = MODE_IDLE;
            if (lvl_q) begin
               mode_q = MODE_RUN;
               start_sec = t.secs;
               elapsed_cnt = '0;
               on_sum = '0;
               off_sum = '0;
               r.ev = EV_START;
            end
         end
      endcase
      r.md = mode_q;
      r.on_ticks = on_sum;
      r.off_ticks = off_sum;
      r.start_sec = start_sec;
      r.end_sec = end_sec;
      return r;
   endfunction

   // random gaps, with occasional stretches of back-to-back traffic
   task automatic draw_gap(inout int burst, output int gap);
      if (burst > 0) begin
         burst--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(20, 60);
         gap = 0;
      end else
         gap = $urandom_range(0, 18);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", name, want, got);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      logic vld;
      vld = req_tvalid;
      if (reset)
         vld = 1'b0;
      else begin
         if (req_fire_seen)
            vld = 1'b0;
         if (!vld) begin
            if (req_gap > 0)
               req_gap--;
            else if (pending_ticks.size() != 0 &&
                     (!pending_ticks[0].drain || meter_expected.size() == 0)) begin
               cur_tick = pending_ticks.pop_front();
               req_tdata <= {6'b0, cur_tick.secs, cur_tick.rev, cur_tick.fwd};
               vld = 1'b1;
               draw_gap(req_burst, req_gap);
            end
         end
      end
      req_tvalid <= vld;
   end

   // result receiver; a long hold-off lets the block fill and stall its input
   always @(negedge clock) begin
      logic rdy;
      if (reset)
         rdy = 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = 300;
         rdy = 1'b0;
      end else begin
         if (rsp_fire_seen)
            draw_gap(rsp_burst, rsp_wait);
         if (rsp_wait > 0) begin
            rsp_wait--;
            rdy = 1'b0;
         end else
            rdy = 1'b1;
      end
      rsp_tready <= rdy;
   end

   // monitor: predict on each accepted request, compare each accepted result
   always @(posedge clock) begin
      meter_result_type want;
      req_fire_seen <= !reset && req_tvalid && req_tready;
      rsp_fire_seen <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready)
         meter_expected = {meter_expected, advance_meter(cur_tick)};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (meter_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h", rsp_tdata);
         end else begin
            want = meter_expected.pop_front();
            check_field("event_res", 32'(want.ev), 32'(rsp_tdata[2:0]));
            check_field("mode", 32'(want.md), 32'(rsp_tdata[4:3]));
            check_field("on_ticks", want.on_ticks, rsp_tdata[36:5]);
            check_field("off_ticks", want.off_ticks, rsp_tdata[68:37]);
            check_field("start_seconds", want.start_sec, rsp_tdata[100:69]);
            check_field("end_seconds", want.end_sec, rsp_tdata[132:101]);
            check_field("pad", 32'd0, 32'(rsp_tdata[135:133]));
         end
      end
   end

   task automatic queue_tick(bit fwd, bit rev, logic [31:0] secs, bit drain = 1'b0);
      meter_tick_type t;
      t.fwd = fwd;
      t.rev = rev;
      t.secs = secs;
      t.drain = drain;
      pending_ticks = {pending_ticks, t};
   endtask

   // sampled at the rising edge so the driver's falling-edge updates have settled
   task automatic wait_idle();
      @(posedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || meter_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_DEBOUNCE)
         cfg_debounce = data[DEBOUNCE_BITS-1:0];
      else
         cfg_timeout = data[TIMEOUT_BITS-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one level held for a while, with the active pin pattern varying per request
   task automatic queue_level(bit on, int len, bit drain);
      int   k;
      logic [1:0] pins;
      for (k = 0; k < len; k++) begin
         pins = on ? 2'($urandom_range(1, 3)) : 2'b00;
         if ($urandom_range(0, 49) == 0)
            wall_now = $urandom;
         else
            wall_now = wall_now + 1;
         queue_tick(pins[0], pins[1], wall_now, drain && k == 0);
      end
   endtask

   // mostly well-formed on/off runs around the debounce and timeout lengths
   task automatic queue_runs(int budget);
      int left, len, sel, deb, tout;
      left = budget;
      deb = int'(cfg_debounce);
      tout = (cfg_timeout > 40) ? 40 : int'(cfg_timeout);
      while (left > 0) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            len = $urandom_range(1, deb + 12);
            queue_level(1'b1, len, $urandom_range(0, 59) == 0);
         end else if (sel < 8) begin
            len = $urandom_range(1, deb + tout + 5);
            queue_level(1'b0, len, $urandom_range(0, 59) == 0);
         end else if (sel == 8) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++)
               queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                          1'b0);
         end else begin
            // glitch just short of, at, or just past the debounce length
            len = $urandom_range((deb > 0) ? deb : 1, deb + 2);
            queue_level(1'($urandom_range(0, 1)), len, 1'b0);
         end
         left -= len;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: pin patterns and second extremes, nothing qualifies yet
      queue_tick(1'b0, 1'b0, 32'h0000_0000);
      queue_tick(1'b1, 1'b0, 32'hFFFF_FFFF);
      queue_tick(1'b0, 1'b1, 32'h8000_0000);
      queue_tick(1'b1, 1'b1, 32'h7FFF_FFFF);

      // upper bits must be dropped, leaving immediate acceptance
      write_csr(CSR_DEBOUNCE, 32'hFFFF_FC00);
      write_csr(CSR_TIMEOUT, 32'd0);
      queue_tick(1'b1, 1'b0, 32'hFFFF_FFFF);   // start
      queue_tick(1'b0, 1'b1, 32'd1);
      queue_tick(1'b0, 1'b0, 32'd2);           // pause
      queue_tick(1'b0, 1'b0, 32'd3);           // finish at once with zero timeout
      queue_tick(1'b0, 1'b0, 32'd4);
      queue_tick(1'b1, 1'b1, 32'd5);           // start clears totals, keeps end stamp
      queue_tick(1'b0, 1'b0, 32'd6);
      queue_tick(1'b1, 1'b0, 32'd7);           // resume
      queue_tick(1'b0, 1'b1, 32'd8);
      queue_tick(1'b0, 1'b0, 32'd9);
      queue_tick(1'b0, 1'b0, 32'd10, 1'b1);

      write_csr(CSR_DEBOUNCE, 32'd2);
      write_csr(CSR_TIMEOUT, 32'd1);
      queue_tick(1'b1, 1'b0, 32'd20);
      queue_tick(1'b1, 1'b0, 32'd21);
      queue_tick(1'b0, 1'b0, 32'd22);          // glitch too short to qualify
      queue_tick(1'b0, 1'b1, 32'd23);
      queue_tick(1'b0, 1'b1, 32'd24);
      queue_tick(1'b1, 1'b1, 32'd25);          // accepted, start
      queue_tick(1'b0, 1'b0, 32'd26);
      queue_tick(1'b0, 1'b0, 32'd27);

      write_csr(CSR_DEBOUNCE, 32'd0);
      write_csr(CSR_TIMEOUT, 32'd1);
      queue_runs(40);

      write_csr(CSR_DEBOUNCE, 32'd3);
      write_csr(CSR_TIMEOUT, 32'd7);
      @(posedge clock);
      hold_req = !hold_req;
      queue_runs(50);

      write_csr(CSR_DEBOUNCE, 32'd1);
      write_csr(CSR_TIMEOUT, 32'd2);
      queue_runs(40);

      write_csr(CSR_DEBOUNCE, 32'd6);
      write_csr(CSR_TIMEOUT, 32'd25);
      queue_runs(50);

      write_csr(CSR_DEBOUNCE, 32'd0);
      write_csr(CSR_TIMEOUT, 32'd0);
      queue_runs(30);

      write_csr(CSR_DEBOUNCE, 32'd12);
      write_csr(CSR_TIMEOUT, 32'd4);
      queue_runs(50);

      // longest debounce and a timeout the counter never reaches in this run
      write_csr(CSR_DEBOUNCE, 32'hFFFF_FFFF);
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFF);
      queue_level(1'b1, 1030, 1'b0);
      queue_level(1'b0, 30, 1'b0);

      begin
         int spin;
         spin = 0;
         @(posedge clock);
         while ((pending_ticks.size() != 0 || req_tvalid || meter_expected.size() != 0)
                && spin < 200000) begin
            spin++;
            @(posedge clock);
         end
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0 && meter_expected.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #6000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
